/* sv/tqem_pkg.sv */
// ----------------------------------------------------------------------------
// tqem_pkg
// Shared types, constants and helpers for the triple qualified enable monitor.
// ----------------------------------------------------------------------------
package tqem_pkg;

  localparam int unsigned AGE_W    = 7;
  localparam int unsigned CAL_W    = 8;
  localparam int unsigned BOUND_W  = 16;
  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned THR_W    = 10;  // max (255*5)/2 = 637
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [AGE_W-1:0]   AGE_MAX         = 7'd127;
  localparam logic [BOUND_W-1:0] BATTERY_MIN_RST = 16'h0000;
  localparam logic [BOUND_W-1:0] BATTERY_MAX_RST = 16'hFFFF;
  localparam logic [CAL_W-1:0]   CAL_RST         = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATTERY_MIN       = 3'd0,
    REG_BATTERY_MAX       = 3'd1,
    REG_WAKE_TICKS_CAL    = 3'd2,
    REG_REQUEST_TICKS_CAL = 3'd3,
    REG_BATTERY_TICKS_CAL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [BOUND_W-1:0] battery_min;
    logic [BOUND_W-1:0] battery_max;
    logic [CAL_W-1:0]   wake_ticks_cal;
    logic [CAL_W-1:0]   request_ticks_cal;
    logic [CAL_W-1:0]   battery_ticks_cal;
  } cfg_t;

  // (cal * 5) / 2 as shift-add, result floors
  function automatic logic [THR_W-1:0] threshold_of(input logic [CAL_W-1:0] cal);
    logic [THR_W:0] sum;
    sum = {3'b000, cal} + {1'b0, cal, 2'b00};
    return sum[THR_W:1];
  endfunction

  function automatic logic [AGE_W-1:0] age_bump(input logic [AGE_W-1:0] age);
    return (age >= AGE_MAX) ? AGE_MAX : age + 7'd1;
  endfunction

endpackage

/* sv/tqem_in_if.sv */
// ----------------------------------------------------------------------------
// tqem_in_if
// Input tick channel: wake flag, restart request and battery sample.
// ----------------------------------------------------------------------------
interface tqem_in_if;
  logic                                valid;
  logic                                ready;
  logic                                wake_main;
  logic                                restart_request;
  logic signed [tqem_pkg::VOLT_W-1:0]  battery_voltage;

  modport source (output valid, wake_main, restart_request, battery_voltage, input ready);
  modport sink   (input valid, wake_main, restart_request, battery_voltage, output ready);
endinterface

/* sv/tqem_out_if.sv */
// ----------------------------------------------------------------------------
// tqem_out_if
// Result channel: one enable bit per tick.
// ----------------------------------------------------------------------------
interface tqem_out_if;
  logic valid;
  logic ready;
  logic diag_enable;

  modport source (output valid, diag_enable, input ready);
  modport sink   (input valid, diag_enable, output ready);
endinterface

/* sv/tqem_cfg_if.sv */
// ----------------------------------------------------------------------------
// tqem_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tqem_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tqem_pkg::CFG_IDX_W-1:0]      index;
  logic [tqem_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tqem_regs.sv */
// ----------------------------------------------------------------------------
// tqem_regs
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tqem_regs (
  input  logic              clk,
  input  logic              rst_n,
  tqem_cfg_if.sink          cfg_bus,
  output tqem_pkg::cfg_t    cfg
);

  tqem_pkg::cfg_t cfg_r;
  tqem_pkg::cfg_t cfg_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      case (tqem_pkg::reg_idx_t'(cfg_bus.index))
        tqem_pkg::REG_BATTERY_MIN:       cfg_nxt.battery_min       = cfg_bus.data;
        tqem_pkg::REG_BATTERY_MAX:       cfg_nxt.battery_max       = cfg_bus.data;
        tqem_pkg::REG_WAKE_TICKS_CAL:    cfg_nxt.wake_ticks_cal    = cfg_bus.data[7:0];
        tqem_pkg::REG_REQUEST_TICKS_CAL: cfg_nxt.request_ticks_cal = cfg_bus.data[7:0];
        tqem_pkg::REG_BATTERY_TICKS_CAL: cfg_nxt.battery_ticks_cal = cfg_bus.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.battery_min       <= tqem_pkg::BATTERY_MIN_RST;
      cfg_r.battery_max       <= tqem_pkg::BATTERY_MAX_RST;
      cfg_r.wake_ticks_cal    <= tqem_pkg::CAL_RST;
      cfg_r.request_ticks_cal <= tqem_pkg::CAL_RST;
      cfg_r.battery_ticks_cal <= tqem_pkg::CAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/tqem_core.sv */
// ----------------------------------------------------------------------------
// tqem_core
// Input register, qualification logic with age counters, result register.
// ----------------------------------------------------------------------------
module tqem_core (
  input  logic              clk,
  input  logic              rst_n,
  input  tqem_pkg::cfg_t    cfg,
  tqem_in_if.sink           in_bus,
  tqem_out_if.source        out_bus
);

  // input stage
  logic                               s1_valid_r;
  logic                               s1_wake_r;
  logic                               s1_req_r;
  logic signed [tqem_pkg::VOLT_W-1:0] s1_volt_r;

  // result stage
  logic out_valid_r;
  logic out_enable_r;
  logic out_enable_nxt;

  // tick state
  logic [tqem_pkg::AGE_W-1:0] wake_age_r,    wake_age_nxt;
  logic [tqem_pkg::AGE_W-1:0] request_age_r, request_age_nxt;
  logic [tqem_pkg::AGE_W-1:0] battery_age_r, battery_age_nxt;
  logic wake_last_r, request_last_r, in_range_last_r;

  logic                       advance;
  logic                       in_range;
  logic [tqem_pkg::AGE_W-1:0] wake_age_clr, request_age_clr, battery_age_clr;
  logic                       c_wake, c_req, c_batt;

  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;

  assign out_bus.valid       = out_valid_r;
  assign out_bus.diag_enable = out_enable_r;

  always_comb begin
    // negative sample never in window; nonnegative compares as unsigned
    in_range = !s1_volt_r[tqem_pkg::VOLT_W-1]
            && (unsigned'(s1_volt_r) >= cfg.battery_min)
            && (unsigned'(s1_volt_r) <= cfg.battery_max);

    wake_age_clr    = (s1_wake_r && !wake_last_r)        ? '0 : wake_age_r;
    request_age_clr = (!s1_req_r && request_last_r)      ? '0 : request_age_r;
    battery_age_clr = (in_range && !in_range_last_r)     ? '0 : battery_age_r;

    c_wake = s1_wake_r && ({3'b000, wake_age_clr}
             >= tqem_pkg::threshold_of(cfg.wake_ticks_cal));
    c_req  = !s1_req_r && ({3'b000, request_age_clr}
             >= tqem_pkg::threshold_of(cfg.request_ticks_cal));
    c_batt = in_range && ({3'b000, battery_age_clr}
             >= tqem_pkg::threshold_of(cfg.battery_ticks_cal));

    out_enable_nxt  = c_wake && c_req && c_batt;
    wake_age_nxt    = tqem_pkg::age_bump(wake_age_clr);
    request_age_nxt = tqem_pkg::age_bump(request_age_clr);
    battery_age_nxt = tqem_pkg::age_bump(battery_age_clr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      wake_age_r      <= '0;
      request_age_r   <= '0;
      battery_age_r   <= '0;
      wake_last_r     <= 1'b0;
      request_last_r  <= 1'b0;
      in_range_last_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r     <= 1'b1;
        wake_age_r      <= wake_age_nxt;
        request_age_r   <= request_age_nxt;
        battery_age_r   <= battery_age_nxt;
        wake_last_r     <= s1_wake_r;
        request_last_r  <= s1_req_r;
        in_range_last_r <= in_range;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_wake_r <= in_bus.wake_main;
      s1_req_r  <= in_bus.restart_request;
      s1_volt_r <= in_bus.battery_voltage;
    end
    if (advance) begin
      out_enable_r <= out_enable_nxt;
    end
  end

endmodule

/* sv/triple_qualified_enable_monitor.sv */
// ----------------------------------------------------------------------------
// triple_qualified_enable_monitor
// Qualifies a diagnostic enable from wake, restart request and battery window.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one beat per tick (wake_main, restart_request, battery_voltage).
//   out_bus : one beat per input beat carrying diag_enable, in order.
//   cfg_bus : register writes (index 0..4), always ready; write only while
//             the block is idle. Writes to other indexes are dropped.
// Pipeline: an accepted beat passes through the input register, then the
//   result register, to out_bus. Throughput is one beat per cycle while
//   out_bus is not stalled; the qualification logic between is combinational.
// Reset (rst_n low, synchronous): both stages empty, age counters and edge
//   history cleared, registers return to their defaults (full window,
//   zero calibrations).
// Stall: while out_bus.ready is low the result holds; one more beat may be
//   taken into the input register, after which in_bus.ready drops until
//   the result is taken.
// ----------------------------------------------------------------------------
module triple_qualified_enable_monitor (
  input  logic         clk,
  input  logic         rst_n,
  tqem_in_if.sink      in_bus,
  tqem_out_if.source   out_bus,
  tqem_cfg_if.sink     cfg_bus
);

  tqem_pkg::cfg_t cfg;

  tqem_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  tqem_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

/* sv/tqem_checker.sv */
// ----------------------------------------------------------------------------
// tqem_checker
// Port-level checks for the triple qualified enable monitor.
// ----------------------------------------------------------------------------
module tqem_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_diag_enable,
  input logic cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_diag_enable))
    else $error("result changed while stalled");

  // input only backs up behind a stalled full output
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input not ready without output stall");

  // an accepted beat keeps a result pending behind the input and result registers
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  // reset empties the pipe; config port stays open
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_ready)
    else $error("output valid or config blocked after reset");

endmodule

bind triple_qualified_enable_monitor tqem_checker u_tqem_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_diag_enable (out_bus.diag_enable),
  .cfg_ready       (cfg_bus.ready)
);
